// ===== rtl/sdct_pkg.sv =====
// ----------------------------------------------------------------------------
// sdct_pkg: shared types and codes of the serial display command translator
// Display command codes, parser modes, protocol control codes, the
// character-set limit, register indexes and the layout of one result.
// ----------------------------------------------------------------------------
package sdct_pkg;

   // display driver commands
   localparam logic [3:0] CMD_WRITE      = 4'd0;
   localparam logic [3:0] CMD_HOME       = 4'd1;
   localparam logic [3:0] CMD_DISP_OFF   = 4'd2;
   localparam logic [3:0] CMD_DISP_ON    = 4'd3;
   localparam logic [3:0] CMD_CURS_OFF   = 4'd4;
   localparam logic [3:0] CMD_CLEAR      = 4'd5;
   localparam logic [3:0] CMD_SET_CURSOR = 4'd6;
   localparam logic [3:0] CMD_SCROLL_ON  = 4'd7;
   localparam logic [3:0] CMD_SCROLL_OFF = 4'd8;
   localparam logic [3:0] CMD_INIT       = 4'd9;

   // parser modes
   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_DISCARD = 2'd1;
   localparam logic [1:0] MODE_COLUMN  = 2'd2;
   localparam logic [1:0] MODE_ROW     = 2'd3;

   // protocol control codes
   localparam logic [7:0] CODE_HOME       = 8'd1;
   localparam logic [7:0] CODE_DISP_OFF   = 8'd2;
   localparam logic [7:0] CODE_DISP_ON    = 8'd3;
   localparam logic [7:0] CODE_CURS_OFF   = 8'd4;
   localparam logic [7:0] CODE_BACKSPACE  = 8'd8;
   localparam logic [7:0] CODE_TAB        = 8'd9;
   localparam logic [7:0] CODE_LINEFEED   = 8'd10;
   localparam logic [7:0] CODE_CLEAR      = 8'd12;
   localparam logic [7:0] CODE_RETURN     = 8'd13;
   localparam logic [7:0] CODE_SKIP_A     = 8'd14;
   localparam logic [7:0] CODE_SKIP_B     = 8'd15;
   localparam logic [7:0] CODE_CURSOR     = 8'd17;
   localparam logic [7:0] CODE_SCROLL_ON  = 8'd19;
   localparam logic [7:0] CODE_SCROLL_OFF = 8'd20;
   localparam logic [7:0] CODE_INIT       = 8'd26;
   localparam logic [7:0] CODE_PRINTABLE  = 8'd32;

   // character sets at or above this value produce no set command
   localparam logic [7:0] CHARSET_LIMIT = 8'd3;

   // configuration register indexes
   localparam logic [1:0] REG_CUSTOM_LOW  = 2'd0;
   localparam logic [1:0] REG_CUSTOM_HIGH = 2'd1;
   localparam logic [1:0] REG_CHARSET     = 2'd2;

   typedef struct packed {
      logic [3:0] command;
      logic [7:0] data_byte;
      logic [7:0] column;
      logic [7:0] row;
      logic       last;
   } result_type;

endpackage

// ===== rtl/serial_display_command_translator.sv =====
// ----------------------------------------------------------------------------
// serial_display_command_translator: protocol bytes to display commands
// Parses a character-display byte stream and emits display driver commands,
// with custom characters, fixed remaps and character-set switching.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------
//   req_     | in        | tvalid / tready      | tdata[7:0] rx_byte
//   rsp_     | out       | tvalid / tready      | tdata command..row, tlast last
//   csr_     | in        | APB psel/penable     | 64-bit registers at 8*i
//
// A request enters the input register and is decoded from there straight
// into the result register. A request that yields one or no result streams
// at one per clock while rsp_ is not stalled; a printable byte that changes
// the character set yields two results and holds the input register until
// the single-entry pending slot behind the result register drains. Reset is
// synchronous and clears the parser state, configuration registers and valid
// flags. A stall on rsp_ backs up into req_tready with no loss.

module serial_display_command_translator
   import sdct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] rx_byte

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,     // [3:0] command, [11:4] data_byte,
                                      // [19:12] column, [27:20] row, zero pad
   output logic        rsp_tlast,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   // configuration registers
   logic [63:0] custom_low_ff;
   logic [63:0] custom_high_ff;
   logic [7:0]  cs_base_ff;

   // input register
   logic        in_vld_ff;
   logic [7:0]  in_byte_ff;

   // parser state
   logic [1:0]  mode_ff, mode_in;
   logic [7:0]  col_ff, col_in;
   logic [1:0]  cs_ff, cs_in;

   // result register and the pending second result
   logic        rsp_vld_ff;
   result_type  rsp_ff;
   logic        pend_vld_ff;
   result_type  pend_ff;

   // decode outputs
   logic [1:0]  n_res;
   result_type  res0, res1;
   logic [15:0] trans;
   logic [15:0] custom_entry;
   logic [63:0] custom_word;
   logic        out_free;
   logic        adv;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   // ---------------------------------------------------------------- config
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:3];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         custom_low_ff  <= '0;
         custom_high_ff <= '0;
         cs_base_ff     <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_CUSTOM_LOW:  custom_low_ff  <= csr_pwdata;
            REG_CUSTOM_HIGH: custom_high_ff <= csr_pwdata;
            REG_CHARSET:     cs_base_ff     <= csr_pwdata[7:0];
            default: ;       // writes beyond the map are dropped
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_CUSTOM_LOW:  csr_prdata = custom_low_ff;
         REG_CUSTOM_HIGH: csr_prdata = custom_high_ff;
         REG_CHARSET:     csr_prdata = {56'd0, cs_base_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------ handshake
   // The decode stage advances once the pending slot is empty and the result
   // register is empty or being emptied; a dropped byte advances the same way.
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign adv        = in_vld_ff && !pend_vld_ff && out_free;
   assign req_tready = !in_vld_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   // ------------------------------------------------------------ translate
   // Custom entries cover bytes 128 to 135; the fixed remaps win over them.
   always_comb begin
      custom_word  = in_byte_ff[2] ? custom_high_ff : custom_low_ff;
      case (in_byte_ff[1:0])
         2'd0:    custom_entry = custom_word[15:0];
         2'd1:    custom_entry = custom_word[31:16];
         2'd2:    custom_entry = custom_word[47:32];
         default: custom_entry = custom_word[63:48];
      endcase

      if (in_byte_ff[7:3] == 5'b10000) begin
         trans = custom_entry;
      end else begin
         trans = {8'd0, in_byte_ff};
      end

      case (in_byte_ff)
         8'hFE:   trans = 16'h02B3;
         8'hC4:   trans = 16'h005F;
         8'hDE:   trans = 16'h01FC;
         8'hE0:   trans = 16'h01FA;
         8'hE1:   trans = 16'h01FD;
         8'hDF:   trans = 16'h01FB;
         8'hFF:   trans = 16'h01F8;
         8'h80:   trans = 16'h01DF;
         default: ;
      endcase
   end

   // --------------------------------------------------------------- decode
   always_comb begin
      n_res   = 2'd0;
      res0    = '0;
      res1    = '0;
      mode_in = mode_ff;
      col_in  = col_ff;
      cs_in   = cs_ff;

      case (mode_ff)
         MODE_DISCARD: begin
            mode_in = MODE_IDLE;
         end
         MODE_COLUMN: begin
            col_in  = in_byte_ff;
            mode_in = MODE_ROW;
         end
         MODE_ROW: begin
            mode_in      = MODE_IDLE;
            n_res        = 2'd1;
            res0.command = CMD_SET_CURSOR;
            res0.column  = col_ff;
            res0.row     = in_byte_ff;
            res0.last    = 1'b1;
         end
         default: begin
            if (in_byte_ff < CODE_PRINTABLE) begin
               res0.last = 1'b1;
               if (in_byte_ff inside {CODE_SKIP_A, CODE_SKIP_B}) begin
                  mode_in = MODE_DISCARD;
               end else if (in_byte_ff == CODE_CURSOR) begin
                  mode_in = MODE_COLUMN;
               end else if (in_byte_ff inside {CODE_BACKSPACE, CODE_TAB,
                                               CODE_LINEFEED, CODE_RETURN}) begin
                  // pass the code through as a plain write
                  n_res          = 2'd1;
                  res0.command   = CMD_WRITE;
                  res0.data_byte = in_byte_ff;
               end else begin
                  n_res = 2'd1;
                  case (in_byte_ff)
                     CODE_HOME:       res0.command = CMD_HOME;
                     CODE_DISP_OFF:   res0.command = CMD_DISP_OFF;
                     CODE_DISP_ON:    res0.command = CMD_DISP_ON;
                     CODE_CURS_OFF:   res0.command = CMD_CURS_OFF;
                     CODE_CLEAR:      res0.command = CMD_CLEAR;
                     CODE_SCROLL_ON:  res0.command = CMD_SCROLL_ON;
                     CODE_SCROLL_OFF: res0.command = CMD_SCROLL_OFF;
                     CODE_INIT:       res0.command = CMD_INIT;
                     default:         n_res        = 2'd0;   // drop unknown codes
                  endcase
               end
            end else if (trans[15:8] != {6'd0, cs_ff} && trans[15:8] < CHARSET_LIMIT) begin
               // switch character set first, then write the character
               n_res          = 2'd2;
               cs_in          = trans[9:8];
               res0.command   = CMD_WRITE;
               res0.data_byte = cs_base_ff + trans[15:8];
               res0.last      = 1'b0;
               res1.command   = CMD_WRITE;
               res1.data_byte = trans[7:0];
               res1.last      = 1'b1;
            end else begin
               n_res          = 2'd1;
               res0.command   = CMD_WRITE;
               res0.data_byte = trans[7:0];
               res0.last      = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         col_ff  <= '0;
         cs_ff   <= '0;
      end else if (adv) begin
         mode_ff <= mode_in;
         col_ff  <= col_in;
         cs_ff   <= cs_in;
      end
   end

   // -------------------------------------------------------------- results
   // Drain the pending slot before anything new; load both slots on a pair.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else if (pend_vld_ff) begin
         if (out_free) begin
            rsp_vld_ff  <= 1'b1;
            pend_vld_ff <= 1'b0;
         end
      end else if (adv && n_res != 2'd0) begin
         rsp_vld_ff  <= 1'b1;
         pend_vld_ff <= (n_res == 2'd2);
      end else if (rsp_tready) begin
         rsp_vld_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_vld_ff) begin
         if (out_free) begin
            rsp_ff <= pend_ff;
         end
      end else if (adv && n_res != 2'd0) begin
         rsp_ff  <= res0;
         pend_ff <= res1;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'd0, rsp_ff.row, rsp_ff.column, rsp_ff.data_byte, rsp_ff.command};
   assign rsp_tlast  = rsp_ff.last;

   // ----------------------------------------------------------- assertions
   a_pend_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> rsp_vld_ff)
      else $error("pending result without a result in front of it");

   a_pend_is_last: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> pend_ff.last)
      else $error("pending result is not the final one of its request");

   a_first_has_second: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ff.last) |-> pend_vld_ff)
      else $error("first result of a pair shown without its second");

   a_cursor_mode: assert property (@(posedge clock) disable iff (reset)
      (adv && mode_ff == MODE_IDLE && in_byte_ff == CODE_CURSOR) |=>
      mode_ff == MODE_COLUMN)
      else $error("cursor code did not open the column argument");

   a_charset_range: assert property (@(posedge clock) disable iff (reset)
      cs_ff != 2'd3)
      else $error("current character set out of range");

endmodule

// ===== tb/sdct_command_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sdct_command_checker: display command predictor and comparator
// Watches the request, result and register channels of the translator, keeps
// its own copy of the parser state and registers, queues the commands each
// request must produce and compares every result against the oldest one.
// ----------------------------------------------------------------------------
module sdct_command_checker
   import sdct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output int          fail_count,
   output int          outstanding
);

   localparam logic [7:0] CUSTOM_BASE  = 8'h80;
   localparam int         CUSTOM_COUNT = 8;
   localparam int         REMAP_COUNT  = 8;
   localparam logic [7:0]  REMAP_FROM [REMAP_COUNT] =
      '{8'hFE, 8'hC4, 8'hDE, 8'hE0, 8'hE1, 8'hDF, 8'hFF, 8'h80};
   localparam logic [15:0] REMAP_TO   [REMAP_COUNT] =
      '{16'h02B3, 16'h005F, 16'h01FC, 16'h01FA, 16'h01FD, 16'h01FB, 16'h01F8,
        16'h01DF};
   localparam int REPORT_LIMIT = 10;

   logic [63:0] custom_low, custom_high;
   logic [7:0]  charset_base;
   logic [1:0]  parse_mode;
   logic [7:0]  saved_column;
   logic [1:0]  current_charset;

   result_type  expected_cmds [$];
   int          reports;

   task automatic queue_command(input logic [3:0] cmd, input logic [7:0] data,
                                input logic [7:0] col, input logic [7:0] row,
                                input logic fin);
      result_type r;
      r.command   = cmd;
      r.data_byte = data;
      r.column    = col;
      r.row       = row;
      r.last      = fin;
      expected_cmds.push_back(r);
   endtask

   // advance the parser by one protocol byte and queue what it emits
   task automatic decode_byte(input logic [7:0] b);
      logic [15:0] glyph;
      logic [7:0]  set_no;
      logic [2:0]  slot;
      case (parse_mode)
         MODE_DISCARD: begin
            parse_mode = MODE_IDLE;
         end
         MODE_COLUMN: begin
            saved_column = b;
            parse_mode   = MODE_ROW;
         end
         MODE_ROW: begin
            parse_mode = MODE_IDLE;
            queue_command(CMD_SET_CURSOR, 8'd0, saved_column, b, 1'b1);
         end
         default: begin
            if (b < CODE_PRINTABLE) begin
               case (b)
                  CODE_SKIP_A, CODE_SKIP_B: parse_mode = MODE_DISCARD;
                  CODE_CURSOR:              parse_mode = MODE_COLUMN;
                  CODE_BACKSPACE, CODE_TAB, CODE_LINEFEED, CODE_RETURN:
                     queue_command(CMD_WRITE, b, 8'd0, 8'd0, 1'b1);
                  CODE_HOME:       queue_command(CMD_HOME, 8'd0, 8'd0, 8'd0, 1'b1);
                  CODE_DISP_OFF:   queue_command(CMD_DISP_OFF, 8'd0, 8'd0, 8'd0, 1'b1);
                  CODE_DISP_ON:    queue_command(CMD_DISP_ON, 8'd0, 8'd0, 8'd0, 1'b1);
                  CODE_CURS_OFF:   queue_command(CMD_CURS_OFF, 8'd0, 8'd0, 8'd0, 1'b1);
                  CODE_CLEAR:      queue_command(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 1'b1);
                  CODE_SCROLL_ON:  queue_command(CMD_SCROLL_ON, 8'd0, 8'd0, 8'd0, 1'b1);
                  CODE_SCROLL_OFF: queue_command(CMD_SCROLL_OFF, 8'd0, 8'd0, 8'd0, 1'b1);
                  CODE_INIT:       queue_command(CMD_INIT, 8'd0, 8'd0, 8'd0, 1'b1);
                  default: ;
               endcase
            end else begin
               glyph = {8'h00, b};
               if (b >= CUSTOM_BASE && b < CUSTOM_BASE + CUSTOM_COUNT) begin
                  slot  = 3'(b - CUSTOM_BASE);
                  glyph = slot[2] ? custom_high[{slot[1:0], 4'b0000} +: 16]
                                  : custom_low[{slot[1:0], 4'b0000} +: 16];
               end
               for (int i = 0; i < REMAP_COUNT; i++)
                  if (b == REMAP_FROM[i]) glyph = REMAP_TO[i];
               set_no = glyph[15:8];
               if (set_no != {6'd0, current_charset} && set_no < CHARSET_LIMIT) begin
                  queue_command(CMD_WRITE, charset_base + set_no, 8'd0, 8'd0, 1'b0);
                  current_charset = set_no[1:0];
               end
               queue_command(CMD_WRITE, glyph[7:0], 8'd0, 8'd0, 1'b1);
            end
         end
      endcase
   endtask

   task automatic report_failure(input string what, input result_type want,
                                 input result_type got);
      fail_count++;
      if (reports < REPORT_LIMIT) begin
         reports++;
         $display("%0t %s: expected cmd %0d data %02h col %02h row %02h last %0b,",
                  $realtime, what, want.command, want.data_byte, want.column,
                  want.row, want.last);
         $display("      got cmd %0d data %02h col %02h row %02h last %0b",
                  got.command, got.data_byte, got.column, got.row, got.last);
      end
   endtask

   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         custom_low      = '0;
         custom_high     = '0;
         charset_base    = '0;
         parse_mode      = MODE_IDLE;
         saved_column    = '0;
         current_charset = '0;
         expected_cmds.delete();
         fail_count      = 0;
         reports         = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:3])
               REG_CUSTOM_LOW:  custom_low   = csr_pwdata;
               REG_CUSTOM_HIGH: custom_high  = csr_pwdata;
               REG_CHARSET:     charset_base = csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            decode_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.command   = rsp_tdata[3:0];
            got.data_byte = rsp_tdata[11:4];
            got.column    = rsp_tdata[19:12];
            got.row       = rsp_tdata[27:20];
            got.last      = rsp_tlast;
            if (expected_cmds.size() == 0) begin
               want = '0;
               report_failure("unexpected command", want, got);
            end else begin
               want = expected_cmds.pop_front();
               if (got != want)
                  report_failure("command mismatch", want, got);
            end
         end
      end
      outstanding <= expected_cmds.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the serial display command translator
// Drives protocol bytes and register writes, idles both stream sides at
// random, forces one long result stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import sdct_pkg::*;

   localparam int QUIET_LIMIT  = 3000;   // cycles with no handshake at all
   localparam int SQUEEZE_LEN  = 200;    // long result hold-off
   localparam int SETTLE_WAIT  = 8;      // in-flight work after the last result
   localparam int CLOSING_WAIT = 20;

   localparam logic [7:0] REMAPPED [7] =
      '{8'hFE, 8'hC4, 8'hDE, 8'hE0, 8'hE1, 8'hDF, 8'hFF};
   localparam logic [7:0] CONTROLS [12] =
      '{CODE_HOME, CODE_DISP_OFF, CODE_DISP_ON, CODE_CURS_OFF, CODE_BACKSPACE,
        CODE_TAB, CODE_LINEFEED, CODE_CLEAR, CODE_RETURN, CODE_SCROLL_ON,
        CODE_SCROLL_OFF, CODE_INIT};
   localparam logic [7:0] CODE_UNUSED = 8'd22;
   localparam logic [7:0] CUSTOM_BASE = 8'h80;

   // directed opening: every command, the pass-through writes, an ignored
   // code, both discard codes (one swallowing a cursor code), a cursor at the
   // byte extremes, custom entries across sets and a fixed remap
   localparam logic [7:0] DIRECTED [25] =
      '{CODE_HOME, CODE_DISP_OFF, CODE_DISP_ON, CODE_CURS_OFF, CODE_BACKSPACE,
        CODE_TAB, CODE_LINEFEED, CODE_CLEAR, CODE_RETURN, CODE_SCROLL_ON,
        CODE_SCROLL_OFF, CODE_INIT, CODE_UNUSED,
        CODE_SKIP_A, 8'hAA, CODE_SKIP_B, CODE_CURSOR,
        CODE_CURSOR, 8'hFF, 8'h00,
        8'h81, 8'h84, 8'h80, 8'hFE, 8'h41};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;     // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;     // [3:0] command, [11:4] data_byte,
                               // [19:12] column, [27:20] row, zero pad
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   int          command_fails;
   int          outstanding;
   logic        squeeze_request;
   bit          steady;        // sender offers back to back when set
   int          sent;

   serial_display_command_translator dut (.*);

   sdct_command_checker command_check (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .fail_count(command_fails), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then a long pause.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Custom table word: most entries land in sets 0..2 so that set switches
   // are frequent; the rest use sets of 3 and above.
   function automatic logic [63:0] custom_word();
      logic [63:0] w;
      logic [7:0]  set_no;
      int          r;
      for (int k = 0; k < 4; k++) begin
         r = $urandom_range(0, 99);
         if (r < 70)      set_no = 8'($urandom_range(0, 2));
         else if (r < 85) set_no = 8'($urandom_range(3, 254));
         else             set_no = 8'hFF;
         w[16*k +: 16] = {set_no, 8'($urandom)};
      end
      return w;
   endfunction

   // APB write: setup cycle, then access cycle until pready, then release.
   task automatic write_register(input logic [1:0] index, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [63:0] low, input logic [63:0] high,
                            input logic [7:0] base);
      write_register(REG_CUSTOM_LOW, low);
      write_register(REG_CUSTOM_HIGH, high);
      write_register(REG_CHARSET, {56'd0, base});
   endtask

   // Offer one request and hold it until accepted. Valid stays high on return
   // so a back-to-back request needs no second assignment in the same step.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = steady ? 0 : idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // Drop valid, wait for every expected command, then let in-flight work
   // (requests that yield nothing) settle before touching the registers.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // One well-formed sequence with random content, or a bit of noise.
   task automatic send_sequence();
      int r;
      int pick;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         pick = $urandom_range(0, 9);
         if (pick < 3)      send_byte(CUSTOM_BASE + 8'($urandom_range(0, 7)));
         else if (pick < 5) send_byte(REMAPPED[$urandom_range(0, 6)]);
         else               send_byte(8'($urandom_range(32, 255)));
      end else if (r < 50) begin
         send_byte(CODE_CURSOR);
         send_byte(8'($urandom));
         send_byte(8'($urandom));
      end else if (r < 60) begin
         send_byte($urandom_range(0, 1) ? CODE_SKIP_A : CODE_SKIP_B);
         send_byte(8'($urandom));
      end else if (r < 80) begin
         send_byte(CONTROLS[$urandom_range(0, 11)]);
      end else if (r < 88) begin
         send_byte(8'($urandom_range(0, 31)));
      end else begin
         send_byte(8'($urandom));
      end
   endtask

   task automatic run_random(input int count);
      int goal;
      goal = sent + count;
      while (sent < goal) begin
         // occasional stretches with no sender idling
         steady = ($urandom_range(0, 9) == 0);
         send_sequence();
      end
      steady = 1'b0;
   endtask

   // Result side: long ready stretches mixed with random stalls. Once the
   // squeeze is requested, hold ready low for a long count so the block
   // backs up into the request side.
   initial begin
      int gap;
      bit squeezed;
      squeezed   = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (squeeze_request && !squeezed) begin
            squeezed = 1'b1;
            rsp_tready <= 1'b0;
            for (int n = 0; n < SQUEEZE_LEN; n++) @(posedge clock);
         end
         if ($urandom_range(0, 9) < 3) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(10, 60)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
            gap = idle_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   // Watchdog: end the run once nothing has moved on any channel for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   // Main sequence.
   initial begin
      reset           <= 1'b1;
      req_tvalid      <= 1'b0;
      req_tdata       <= '0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      squeeze_request <= 1'b0;
      steady = 1'b0;
      sent   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // custom entries spread over sets 1, 2, 0 and 3 and above
      configure(64'h0000_0233_0141_0155, 64'h02FF_0120_FF7E_0399, 8'hF0);
      foreach (DIRECTED[i]) send_byte(DIRECTED[i]);
      drain();

      configure(custom_word(), custom_word(), 8'($urandom));
      run_random(150);
      drain();

      // all-ones extremes; long result stall with the sender pushing hard
      configure('1, '1, 8'hFF);
      squeeze_request <= 1'b1;
      steady = 1'b1;
      for (int i = 0; i < 40; i++) send_sequence();
      steady = 1'b0;
      run_random(60);
      drain();

      // all-zero extremes: every custom entry in set 0
      configure('0, '0, 8'h00);
      run_random(150);
      drain();

      configure(custom_word(), custom_word(), 8'($urandom));
      run_random(110);
      drain();

      repeat (CLOSING_WAIT) @(posedge clock);
      if (command_fails == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sdct_pkg.sv
rtl/serial_display_command_translator.sv
tb/sdct_command_checker.sv
tb/tb_top.sv
